// File: src/fixed_block_pool_allocator_macros.svh
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FBPA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbpa assertion failed");

// next-cycle implication
`define FBPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbpa assertion failed");

`endif

// File: src/fbpa_pkg.sv
`default_nettype none

package fbpa_pkg;

   localparam int POOL_SLOTS  = 1024;
   localparam int IDX_W       = $clog2(POOL_SLOTS);
   localparam int TOP_W       = IDX_W + 1;

   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 16;
   localparam int TAKEN_W     = 11;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT_SIZE    = 2'd1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REWIND  = 2'd2,
      OP_DEFRAG  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEFRAG,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [SIZE_W-1:0] slot_size;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [ADDR_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

// File: src/fbpa_ram.sv
`default_nettype none

module fbpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/fbpa_ctrl.sv
`default_nettype none

module fbpa_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [1:0]                    req_op,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]   req_free_address,
   input  wire fbpa_pkg::cfg_type             cfg,
   output fbpa_pkg::ram_req_type              ram_req,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]   ram_rd_data,
   output logic                               rsp_strobe,
   output logic [fbpa_pkg::ADDR_W-1:0]        rsp_slot_address,
   output logic [1:0]                         rsp_status,
   output logic [fbpa_pkg::TAKEN_W-1:0]       rsp_taken_count
);

   fbpa_pkg::state_type               state_ff, state_in;
   logic [fbpa_pkg::TOP_W-1:0]        top_ff, top_in;
   logic [fbpa_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [fbpa_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   fbpa_pkg::status_type              status_ff, status_in;
   logic                              sel_ram_ff, sel_ram_in;

   logic                              accept;
   logic                              pool_empty;
   logic                              pool_zero;
   fbpa_pkg::op_type                  op;

   assign accept     = start && (state_ff == fbpa_pkg::S_IDLE);
   assign op         = fbpa_pkg::op_type'(req_op);
   assign pool_empty = (top_ff == fbpa_pkg::TOP_W'(fbpa_pkg::POOL_SLOTS));
   assign pool_zero  = (top_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fbpa_pkg::S_IDLE;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
      end
      idx_ff     <= idx_in;
      addr_ff    <= addr_in;
      status_ff  <= status_in;
      sel_ram_ff <= sel_ram_in;
   end

   always_comb begin
      state_in        = state_ff;
      top_in          = top_ff;
      idx_in          = idx_ff;
      addr_in         = addr_ff;
      status_in       = status_ff;
      sel_ram_in      = sel_ram_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = idx_ff;
      ram_req.wr_data = addr_ff;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = top_ff[fbpa_pkg::IDX_W-1:0];

      unique case (state_ff)
         fbpa_pkg::S_IDLE: begin
            if (accept) begin
               status_in  = fbpa_pkg::ST_OK;
               sel_ram_in = 1'b0;
               state_in   = fbpa_pkg::S_RESP;
               unique case (op)
                  fbpa_pkg::OP_ALLOC: begin
                     if (pool_empty) begin
                        status_in = fbpa_pkg::ST_EMPTY;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        sel_ram_in    = 1'b1;
                        top_in        = top_ff + 1'b1;
                     end
                  end
                  fbpa_pkg::OP_RELEASE: begin
                     if (pool_zero) begin
                        status_in = fbpa_pkg::ST_UNDERFLOW;
                     end else begin
                        top_in          = top_ff - 1'b1;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_addr = top_in[fbpa_pkg::IDX_W-1:0];
                        ram_req.wr_data = req_free_address;
                     end
                  end
                  fbpa_pkg::OP_REWIND: begin
                     top_in = '0;
                  end
                  fbpa_pkg::OP_DEFRAG: begin
                     idx_in   = '0;
                     addr_in  = cfg.base_address;
                     state_in = fbpa_pkg::S_DEFRAG;
                  end
               endcase
            end
         end
         fbpa_pkg::S_DEFRAG: begin
            // one table entry per cycle, running address
            ram_req.wr_en = 1'b1;
            idx_in        = idx_ff + 1'b1;
            addr_in       = addr_ff + {{(fbpa_pkg::ADDR_W-fbpa_pkg::SIZE_W){1'b0}},
                                       cfg.slot_size};
            if (idx_ff == fbpa_pkg::IDX_W'(fbpa_pkg::POOL_SLOTS - 1)) begin
               state_in = fbpa_pkg::S_RESP;
            end
         end
         fbpa_pkg::S_RESP: begin
            state_in = fbpa_pkg::S_IDLE;
         end
         default: begin
            state_in = fbpa_pkg::S_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != fbpa_pkg::S_IDLE);
   assign rsp_strobe       = (state_ff == fbpa_pkg::S_RESP);
   assign rsp_slot_address = sel_ram_ff ? ram_rd_data : '0;
   assign rsp_status       = status_ff;
   assign rsp_taken_count  = fbpa_pkg::TAKEN_W'(top_ff);

endmodule

`default_nettype wire

// File: src/fixed_block_pool_allocator.sv
// Fixed-size block pool: a stack of free slot addresses in a single-port-write,
// registered-read table RAM. Alloc, release and rewind go from the accept
// cycle (table read for alloc, write for release) straight to the result
// cycle. Defrag rewrites the table one entry per cycle through the RAM write
// port, then gives its result. Every word gets exactly one result, shown for
// one cycle with rsp_strobe; the receiver cannot stall, so it must take the
// word in that cycle. Table contents are undefined after reset: issue defrag
// before the first alloc. Configuration is ready and taken only while busy and
// start are both low, so a register never changes under an op in flight.
`default_nettype none

module fixed_block_pool_allocator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [1:0]                        req_op,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]       req_free_address,
   output logic                                   rsp_strobe,
   output logic [fbpa_pkg::ADDR_W-1:0]            rsp_slot_address,
   output logic [1:0]                             rsp_status,
   output logic [fbpa_pkg::TAKEN_W-1:0]           rsp_taken_count,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [fbpa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [fbpa_pkg::ADDR_W-1:0]       csr_data
);

   fbpa_pkg::cfg_type       cfg_ff, cfg_in;
   fbpa_pkg::ram_req_type   ram_req;
   logic [fbpa_pkg::ADDR_W-1:0] ram_rd_data;

   assign csr_ready = !busy && !start;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= '0;
         cfg_ff.slot_size    <= fbpa_pkg::SIZE_W'(8);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            fbpa_pkg::CSR_BASE_ADDRESS: cfg_in.base_address = csr_data;
            fbpa_pkg::CSR_SLOT_SIZE:    cfg_in.slot_size = csr_data[fbpa_pkg::SIZE_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   fbpa_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_free_address (req_free_address),
      .cfg              (cfg_ff),
      .ram_req          (ram_req),
      .ram_rd_data      (ram_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_address (rsp_slot_address),
      .rsp_status       (rsp_status),
      .rsp_taken_count  (rsp_taken_count)
   );

   fbpa_ram #(
      .WIDTH (fbpa_pkg::ADDR_W),
      .DEPTH (fbpa_pkg::POOL_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// File: src/fbpa_checker.sv
`default_nettype none
`include "fixed_block_pool_allocator_macros.svh"

module fbpa_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              start,
   input wire logic                              busy,
   input wire logic                              rsp_strobe,
   input wire logic [fbpa_pkg::ADDR_W-1:0]       rsp_slot_address,
   input wire logic [1:0]                        rsp_status,
   input wire logic [fbpa_pkg::TAKEN_W-1:0]      rsp_taken_count
);

   // result word only while an op is in flight
   `FBPA_ASSERT_SAME(a_rsp_in_busy, clock, reset, rsp_strobe, busy)

   // accepted op blocks the next one
   `FBPA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // block is free right after its result
   `FBPA_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_strobe, !busy && !rsp_strobe)

   // failed ops hand out no address
   `FBPA_ASSERT_SAME(a_fail_no_addr, clock, reset, rsp_strobe && (rsp_status != fbpa_pkg::ST_OK), rsp_slot_address == '0)

   // empty status only with the pool fully taken
   `FBPA_ASSERT_SAME(a_empty_full, clock, reset, rsp_strobe && (rsp_status == fbpa_pkg::ST_EMPTY), rsp_taken_count == fbpa_pkg::TAKEN_W'(fbpa_pkg::POOL_SLOTS))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_slot_address (rsp_slot_address),
   .rsp_status       (rsp_status),
   .rsp_taken_count  (rsp_taken_count)
);

`default_nettype wire

// File: test/tb_fixed_block_pool_allocator.sv
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;

   localparam int TOTAL_WORDS    = 1650;
   localparam int QUIET_FROM     = 1500;
   localparam int WATCHDOG_LIMIT = 4 * (fbpa_pkg::POOL_SLOTS + 20);

   typedef struct {
      logic [fbpa_pkg::ADDR_W-1:0]  slot_address;
      fbpa_pkg::status_type         status;
      logic [fbpa_pkg::TAKEN_W-1:0] taken;
   } pool_result;

   class pool_scoreboard;
      logic [fbpa_pkg::ADDR_W-1:0] base_address;
      logic [fbpa_pkg::SIZE_W-1:0] slot_size;
      logic [fbpa_pkg::ADDR_W-1:0] slot_table [fbpa_pkg::POOL_SLOTS];
      logic [fbpa_pkg::TOP_W-1:0]  top_position;
      bit                          table_filled;
      pool_result                  pending_results[$];
      int                          errors;

      function new();
         base_address = '0;
         slot_size    = 16'd8;
         top_position = '0;
         table_filled = 1'b0;
         errors       = 0;
      endfunction

      function void write_register(logic [fbpa_pkg::CSR_INDEX_W-1:0] index,
                                   logic [fbpa_pkg::ADDR_W-1:0] data);
         case (index)
            fbpa_pkg::CSR_BASE_ADDRESS: base_address = data;
            fbpa_pkg::CSR_SLOT_SIZE:    slot_size = data[fbpa_pkg::SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_word(fbpa_pkg::op_type op,
                              logic [fbpa_pkg::ADDR_W-1:0] free_address);
         pool_result                  r;
         logic [fbpa_pkg::ADDR_W-1:0] addr;
         int                          i;
         r.slot_address = '0;
         r.status       = fbpa_pkg::ST_OK;
         case (op)
            fbpa_pkg::OP_ALLOC: begin
               if (top_position == fbpa_pkg::POOL_SLOTS) begin
                  r.status = fbpa_pkg::ST_EMPTY;
               end else begin
                  r.slot_address = slot_table[top_position[fbpa_pkg::IDX_W-1:0]];
                  top_position++;
               end
            end
            fbpa_pkg::OP_RELEASE: begin
               if (top_position == 0) begin
                  r.status = fbpa_pkg::ST_UNDERFLOW;
               end else begin
                  top_position--;
                  slot_table[top_position[fbpa_pkg::IDX_W-1:0]] = free_address;
               end
            end
            fbpa_pkg::OP_REWIND: begin
               top_position = '0;
            end
            default: begin
               addr = base_address;
               for (i = 0; i < fbpa_pkg::POOL_SLOTS; i++) begin
                  slot_table[i] = addr;
                  addr = addr + slot_size;
               end
               table_filled = 1'b1;
            end
         endcase
         r.taken = top_position;
         pending_results.push_back(r);
      endfunction

      function void check_word(logic [fbpa_pkg::ADDR_W-1:0] slot_address, logic [1:0] status,
                               logic [fbpa_pkg::TAKEN_W-1:0] taken);
         pool_result r;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected word: slot_address %h status %0d taken_count %0d",
                     $time, slot_address, status, taken);
            errors++;
            return;
         end
         r = pending_results.pop_front();
         if (slot_address !== r.slot_address) begin
            $display("%0t: slot_address expected %h actual %h",
                     $time, r.slot_address, slot_address);
            errors++;
         end
         if (status !== r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, r.status, status);
            errors++;
         end
         if (taken !== r.taken) begin
            $display("%0t: taken_count expected %0d actual %0d", $time, r.taken, taken);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [1:0]                       req_op = fbpa_pkg::OP_ALLOC;
   logic [fbpa_pkg::ADDR_W-1:0]      req_free_address = '0;
   logic                             rsp_strobe;
   logic [fbpa_pkg::ADDR_W-1:0]      rsp_slot_address;
   logic [1:0]                       rsp_status;
   logic [fbpa_pkg::TAKEN_W-1:0]     rsp_taken_count;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [fbpa_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [fbpa_pkg::ADDR_W-1:0]      csr_data = '0;

   pool_scoreboard sb;
   int             words_sent = 0;
   int             stall_cycles = 0;
   bit             drain_done = 1'b0;
   int             drain_at;

   fixed_block_pool_allocator DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_free_address (req_free_address),
      .rsp_strobe       (rsp_strobe),
      .rsp_slot_address (rsp_slot_address),
      .rsp_status       (rsp_status),
      .rsp_taken_count  (rsp_taken_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_word(rsp_slot_address, rsp_status, rsp_taken_count);
         end
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic [fbpa_pkg::ADDR_W-1:0] rand_address();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // alloc before the table was ever filled would read undefined entries
   task automatic send_word(input fbpa_pkg::op_type op,
                            input logic [fbpa_pkg::ADDR_W-1:0] free_address);
      fbpa_pkg::op_type actual_op;
      actual_op = op;
      if (op == fbpa_pkg::OP_ALLOC && !sb.table_filled) begin
         actual_op = fbpa_pkg::OP_DEFRAG;
      end
      start            <= 1'b1;
      req_op           <= actual_op;
      req_free_address <= free_address;
      do @(posedge clock); while (busy);
      sb.note_word(actual_op, free_address);
      words_sent++;
   endtask

   task automatic pace(input bit gaps_on);
      if (gaps_on && words_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0 || busy);
   endtask

   task automatic write_csr(input logic [fbpa_pkg::CSR_INDEX_W-1:0] index,
                            input logic [fbpa_pkg::ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_register(index, data);
   endtask

   task automatic random_config();
      int n;
      int i;
      logic [fbpa_pkg::ADDR_W-1:0] value;
      wait_idle();
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0: value = '0;
            1: value = '1;
            2: value = 32'd1;
            3: value = 32'h0000_FFFF;
            default: value = $urandom;
         endcase
         write_csr(fbpa_pkg::CSR_INDEX_W'($urandom_range(0, 3)), value);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic churn_segment();
      int len;
      int i;
      int pick;
      int alloc_w;
      bit gaps_on;
      len     = $urandom_range(8, 48);
      alloc_w = $urandom_range(0, 1) ? 60 : 35;
      gaps_on = $urandom_range(0, 2) != 0;
      for (i = 0; i < len; i++) begin
         pace(gaps_on);
         pick = $urandom_range(0, 99);
         if (pick < alloc_w) begin
            send_word(fbpa_pkg::OP_ALLOC, rand_address());
         end else if (pick < 92) begin
            send_word(fbpa_pkg::OP_RELEASE, rand_address());
         end else if (pick < 98) begin
            send_word(fbpa_pkg::OP_REWIND, rand_address());
         end else begin
            send_word(fbpa_pkg::OP_DEFRAG, rand_address());
         end
      end
   endtask

   // run the pool dry and past it
   task automatic drain_segment();
      int empties;
      bit gaps_on;
      gaps_on = $urandom_range(0, 1) != 0;
      empties = 0;
      send_word(fbpa_pkg::OP_REWIND, rand_address());
      while (empties < 3) begin
         pace(gaps_on);
         if (sb.top_position == fbpa_pkg::POOL_SLOTS) begin
            empties++;
            send_word(fbpa_pkg::OP_ALLOC, rand_address());
         end else if ($urandom_range(0, 15) == 0) begin
            send_word(fbpa_pkg::OP_RELEASE, rand_address());
         end else begin
            send_word(fbpa_pkg::OP_ALLOC, rand_address());
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(fbpa_pkg::OP_RELEASE, '1);
      send_word(fbpa_pkg::OP_REWIND, '1);
      send_word(fbpa_pkg::OP_DEFRAG, '0);
      send_word(fbpa_pkg::OP_ALLOC, '1);
      send_word(fbpa_pkg::OP_ALLOC, '0);
      send_word(fbpa_pkg::OP_RELEASE, '1);
      send_word(fbpa_pkg::OP_ALLOC, '0);
      send_word(fbpa_pkg::OP_RELEASE, '0);
      send_word(fbpa_pkg::OP_REWIND, $urandom);
      send_word(fbpa_pkg::OP_RELEASE, $urandom);
      send_word(fbpa_pkg::OP_ALLOC, $urandom);

      wait_idle();
      write_csr(fbpa_pkg::CSR_BASE_ADDRESS, '1);
      write_csr(fbpa_pkg::CSR_SLOT_SIZE, 32'h0000_FFFF);
      csr_valid <= 1'b0;
      send_word(fbpa_pkg::OP_DEFRAG, $urandom);
      send_word(fbpa_pkg::OP_ALLOC, $urandom);
      send_word(fbpa_pkg::OP_ALLOC, $urandom);

      // zero slot size via masking, plus writes to unused indexes
      wait_idle();
      write_csr(fbpa_pkg::CSR_SLOT_SIZE, 32'hABCD_0000);
      write_csr(2'd2, $urandom);
      write_csr(2'd3, $urandom);
      write_csr(fbpa_pkg::CSR_BASE_ADDRESS, $urandom);
      csr_valid <= 1'b0;
      send_word(fbpa_pkg::OP_DEFRAG, $urandom);
      send_word(fbpa_pkg::OP_REWIND, $urandom);
      send_word(fbpa_pkg::OP_ALLOC, $urandom);
      send_word(fbpa_pkg::OP_ALLOC, $urandom);

      drain_at = words_sent + $urandom_range(0, 300);
      while (words_sent < TOTAL_WORDS) begin
         if (!drain_done && words_sent >= drain_at) begin
            drain_segment();
            drain_done = 1'b1;
         end else begin
            if (words_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
               random_config();
            end
            churn_segment();
         end
      end

      start <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (fbpa_pkg::POOL_SLOTS + 4) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/fbpa_pkg.sv
src/fbpa_ram.sv
src/fbpa_ctrl.sv
src/fixed_block_pool_allocator.sv
src/fbpa_checker.sv
test/tb_fixed_block_pool_allocator.sv
